// ===== hw/rtl/b2uyvy_pkg.sv =====
// ----------------------------------------------------------------------------
// b2uyvy_pkg
// Shared types, widths and fixed-point coefficients for the BGR888 pair to
// UYVY 4:2:2 converter (BT.601 luma, analog YUV chroma).
// ----------------------------------------------------------------------------
package b2uyvy_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int COMP_W        = 8;
   localparam int SUM_W         = COMP_W + 1;
   localparam int COEF_W        = FRACTION_BITS + 1;
   localparam int PROD_W        = COEF_W + SUM_W + 1;
   localparam int ACC_W         = FRACTION_BITS + 13;
   localparam int SHIFTED_W     = ACC_W - FRACTION_BITS;
   localparam int PIPE_DEPTH    = 4;

   localparam longint DEC_SCALE = 10000000;

   // Coefficients are given in units of 1e-7 and rounded to nearest.
   function automatic logic signed [COEF_W-1:0] fx_coef(input longint n, input logic neg);
      longint m;
      m = ((n <<< FRACTION_BITS) + DEC_SCALE / 2) / DEC_SCALE;
      if (neg) begin
         m = -m;
      end
      return m[COEF_W-1:0];
   endfunction

   typedef struct packed {
      logic signed [COEF_W-1:0] r;
      logic signed [COEF_W-1:0] g;
      logic signed [COEF_W-1:0] b;
   } coef_set_type;

   typedef struct packed {
      logic [SUM_W-1:0] r;
      logic [SUM_W-1:0] g;
      logic [SUM_W-1:0] b;
   } rgb_sum_type;

   localparam coef_set_type COEF_Y = '{
      r: fx_coef(2990000, 1'b0),
      g: fx_coef(5870000, 1'b0),
      b: fx_coef(1140000, 1'b0)
   };
   localparam coef_set_type COEF_U = '{
      r: fx_coef(1471300, 1'b1),
      g: fx_coef(2888600, 1'b1),
      b: fx_coef(4360000, 1'b0)
   };
   localparam coef_set_type COEF_V = '{
      r: fx_coef(6150000, 1'b0),
      g: fx_coef(5149900, 1'b1),
      b: fx_coef(1000100, 1'b1)
   };

   localparam logic signed [ACC_W-1:0] CHROMA_OFFSET =
      ACC_W'(128) <<< (FRACTION_BITS + 1);
   localparam logic [COMP_W-1:0] BYTE_MAX = 8'd255;

endpackage

// ===== hw/rtl/b2uyvy_ifs.sv =====
// ----------------------------------------------------------------------------
// b2uyvy channel interfaces
// Valid/ready channels for pixel-pair items and UYVY result items.
// ----------------------------------------------------------------------------
interface b2uyvy_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue_first;
   logic [7:0] green_first;
   logic [7:0] red_first;
   logic [7:0] blue_second;
   logic [7:0] green_second;
   logic [7:0] red_second;
   logic       frame_end_in;

   modport source (
      output valid, blue_first, green_first, red_first,
             blue_second, green_second, red_second, frame_end_in,
      input  ready
   );
   modport sink (
      input  valid, blue_first, green_first, red_first,
             blue_second, green_second, red_second, frame_end_in,
      output ready
   );
endinterface

interface b2uyvy_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] chroma_u;
   logic [7:0] luma_first;
   logic [7:0] chroma_v;
   logic [7:0] luma_second;
   logic       frame_end_out;

   modport source (
      output valid, chroma_u, luma_first, chroma_v, luma_second, frame_end_out,
      input  ready
   );
   modport sink (
      input  valid, chroma_u, luma_first, chroma_v, luma_second, frame_end_out,
      output ready
   );
endinterface

// ===== hw/rtl/b2uyvy_lane.sv =====
// ----------------------------------------------------------------------------
// b2uyvy_lane
// One weighted-sum lane: three products, sum with optional chroma offset,
// then floor and clamp to a byte. Three register stages, all gated by one
// advance enable.
// ----------------------------------------------------------------------------
module b2uyvy_lane (
   input  logic                         clock,
   input  logic                         advance,
   input  logic                         is_chroma,
   input  b2uyvy_pkg::coef_set_type     coef,
   input  b2uyvy_pkg::rgb_sum_type      comp,
   output logic [b2uyvy_pkg::COMP_W-1:0] result
);
   import b2uyvy_pkg::*;

   logic signed [PROD_W-1:0]    prod_r_in, prod_g_in, prod_b_in;
   logic signed [PROD_W-1:0]    prod_r_ff, prod_g_ff, prod_b_ff;
   logic                        chroma_a_ff, chroma_b_ff;
   logic signed [ACC_W-1:0]     acc_in, acc_ff;
   logic [SHIFTED_W-1:0]        shifted;
   logic [COMP_W-1:0]           result_in, result_ff;

   assign prod_r_in = PROD_W'(coef.r) * PROD_W'($signed({1'b0, comp.r}));
   assign prod_g_in = PROD_W'(coef.g) * PROD_W'($signed({1'b0, comp.g}));
   assign prod_b_in = PROD_W'(coef.b) * PROD_W'($signed({1'b0, comp.b}));

   assign acc_in = ACC_W'(prod_r_ff) + ACC_W'(prod_g_ff) + ACC_W'(prod_b_ff)
                 + (chroma_a_ff ? CHROMA_OFFSET : ACC_W'(0));

   // Chroma carries one extra fraction bit from the pair sum.
   always_comb begin
      if (chroma_b_ff) begin
         shifted = {1'b0, acc_ff[ACC_W-1:FRACTION_BITS+1]};
      end else begin
         shifted = acc_ff[ACC_W-1:FRACTION_BITS];
      end
      if (acc_ff[ACC_W-1]) begin
         result_in = '0;
      end else if (shifted > SHIFTED_W'(BYTE_MAX)) begin
         result_in = BYTE_MAX;
      end else begin
         result_in = shifted[COMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_r_ff   <= prod_r_in;
         prod_g_ff   <= prod_g_in;
         prod_b_ff   <= prod_b_in;
         chroma_a_ff <= is_chroma;
         acc_ff      <= acc_in;
         chroma_b_ff <= chroma_a_ff;
         result_ff   <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ===== hw/rtl/bgr888_to_uyvy422_pair.sv =====
// ----------------------------------------------------------------------------
// bgr888_to_uyvy422_pair
// Converts one horizontal pair of BGR888 pixels into one UYVY 4:2:2 item:
// BT.601 luma per pixel, shared U and V from the pair average.
//
//   Channel   Direction  Handshake           Payload
//   req_if    in         valid/ready         two BGR pixels, frame_end_in
//   rsp_if    out        valid/ready         U, Y0, V, Y1, frame_end_out
//
// One item is accepted per cycle while not stalled. Stages: input register,
// products, sum, clamp into the output register. The pipeline advances as
// a whole whenever the output register is empty or being taken, so a stall
// holds every stage in place. Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module bgr888_to_uyvy422_pair (
   input  logic        clock,
   input  logic        reset,
   b2uyvy_req_if.sink  req_if,
   b2uyvy_rsp_if.source rsp_if
);
   import b2uyvy_pkg::*;

   logic                  advance;
   logic [PIPE_DEPTH-1:0] valid_in, valid_ff;
   logic [PIPE_DEPTH-1:0] frame_end_in, frame_end_ff;
   rgb_sum_type           pair_sum_in, pair_sum_ff;
   rgb_sum_type           first_ff, second_ff;
   logic [COMP_W-1:0]     u_byte, v_byte, y0_byte, y1_byte;

   assign advance = !valid_ff[PIPE_DEPTH-1] || rsp_if.ready;
   assign req_if.ready = advance;

   assign valid_in     = {valid_ff[PIPE_DEPTH-2:0], req_if.valid};
   assign frame_end_in = {frame_end_ff[PIPE_DEPTH-2:0], req_if.frame_end_in};

   assign pair_sum_in.r = SUM_W'(req_if.red_first)   + SUM_W'(req_if.red_second);
   assign pair_sum_in.g = SUM_W'(req_if.green_first) + SUM_W'(req_if.green_second);
   assign pair_sum_in.b = SUM_W'(req_if.blue_first)  + SUM_W'(req_if.blue_second);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         frame_end_ff <= frame_end_in;
         pair_sum_ff  <= pair_sum_in;
         first_ff     <= '{r: SUM_W'(req_if.red_first),  g: SUM_W'(req_if.green_first),
                           b: SUM_W'(req_if.blue_first)};
         second_ff    <= '{r: SUM_W'(req_if.red_second), g: SUM_W'(req_if.green_second),
                           b: SUM_W'(req_if.blue_second)};
      end
   end

   b2uyvy_lane u_lane_u (
      .clock     (clock),
      .advance   (advance),
      .is_chroma (1'b1),
      .coef      (COEF_U),
      .comp      (pair_sum_ff),
      .result    (u_byte)
   );

   b2uyvy_lane u_lane_v (
      .clock     (clock),
      .advance   (advance),
      .is_chroma (1'b1),
      .coef      (COEF_V),
      .comp      (pair_sum_ff),
      .result    (v_byte)
   );

   b2uyvy_lane u_lane_y0 (
      .clock     (clock),
      .advance   (advance),
      .is_chroma (1'b0),
      .coef      (COEF_Y),
      .comp      (first_ff),
      .result    (y0_byte)
   );

   b2uyvy_lane u_lane_y1 (
      .clock     (clock),
      .advance   (advance),
      .is_chroma (1'b0),
      .coef      (COEF_Y),
      .comp      (second_ff),
      .result    (y1_byte)
   );

   assign rsp_if.valid         = valid_ff[PIPE_DEPTH-1];
   assign rsp_if.chroma_u      = u_byte;
   assign rsp_if.luma_first    = y0_byte;
   assign rsp_if.chroma_v      = v_byte;
   assign rsp_if.luma_second   = y1_byte;
   assign rsp_if.frame_end_out = frame_end_ff[PIPE_DEPTH-1];

   // A waiting result must block new input.
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |-> !req_if.ready)
      else $error("input accepted while output is stalled");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      !reset && req_if.valid && req_if.ready |=> valid_ff[0])
      else $error("accepted item did not enter the first stage");

   a_stall_holds_valid: assert property (@(posedge clock) disable iff (reset)
      !reset && !advance |=> $stable(valid_ff))
      else $error("stage valid bits moved during a stall");

   a_advance_shifts: assert property (@(posedge clock) disable iff (reset)
      !reset && advance |=> valid_ff[PIPE_DEPTH-1:1] == $past(valid_ff[PIPE_DEPTH-2:0]))
      else $error("stage valid bits lost or repeated an item");

endmodule
